[hw/rtl/echo_reference_audio_path_top_assert.svh]
// assertion macros for the echo reference audio path
`ifndef ECHO_REFERENCE_AUDIO_PATH_TOP_ASSERT_SVH
`define ECHO_REFERENCE_AUDIO_PATH_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define EARAP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define EARAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/earap_pkg.sv]
// types, constants and gain table for the echo reference audio path
`timescale 1ns / 1ps

package earap_pkg;

    localparam int REF_DEPTH      = 2048;
    localparam int ECHO_DELAY     = 256;
    localparam int ADDR_W         = $clog2(REF_DEPTH);

    localparam int SAMPLE_W       = 16;
    localparam int MIC_WORD_W     = 32;
    localparam int BATCH_W        = 11;
    localparam int INDEX_W        = 10;
    localparam int SPK_WORD_W     = 32;
    localparam int VOLUME_W       = 7;

    localparam int POS_W          = ADDR_W + BATCH_W;

    localparam int IN_DATA_W      = 72;
    localparam int OUT_DATA_W     = 64;

    localparam int MIC_SHIFT      = 12;
    localparam int MIC_SHIFTED_W  = MIC_WORD_W - MIC_SHIFT;
    localparam int SAMPLE_MAX     = 32767;

    localparam int GAIN_FRAC_BITS = 20;
    localparam int SPK_SHIFT      = 16;
    localparam int GAIN_W         = 20;
    localparam int GAIN_DIV       = 12500;
    localparam int VOLUME_MAX     = 100;
    localparam int VOLUME_RESET   = 70;

    localparam int PROD_W         = SAMPLE_W + GAIN_W;
    localparam int PROD_DROP      = GAIN_FRAC_BITS - SPK_SHIFT;

    typedef enum logic
    {
        KIND_SPEAKER = 1'b0,
        KIND_MIC     = 1'b1
    } kind_t;

    typedef logic [GAIN_W-1:0] gain_table_t [0:VOLUME_MAX];

    function automatic gain_table_t build_gain_table();
        gain_table_t      t;
        longint unsigned  sq;
        for (int v = 0; v <= VOLUME_MAX; v++)
        begin
            sq   = longint'(v) * longint'(v);
            t[v] = GAIN_W'((sq << GAIN_FRAC_BITS) / GAIN_DIV);
        end
        return t;
    endfunction

    localparam gain_table_t GAIN_TABLE = build_gain_table();

endpackage

[hw/rtl/echo_reference_audio_path_top.sv]
// echo reference audio path: speaker scaling, mic conversion and reference ring
// items pass stage one and the result register; speaker items write the ring
// throughput: one item per cycle unless m_axis_tready stalls the output
// the ring is cleared logically by a fill flag, so no clearing pass after reset
// rst_n is asynchronous active low; volume returns to 70 and the ring reads zero
`timescale 1ns / 1ps

`include "echo_reference_audio_path_top_assert.svh"

module echo_reference_audio_path_top
    import earap_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic [VOLUME_W-1:0]   cfg_wr_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // speaker_sample, mic_word, mic_batch_len, mic_index, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic                  s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // speaker_word, mic_sample, ref_sample
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind
    output logic                  m_axis_tuser
);

    // input fields
    logic signed [SAMPLE_W-1:0]   in_speaker_sample;
    logic signed [MIC_WORD_W-1:0] in_mic_word;
    logic [BATCH_W-1:0]           in_batch_len;
    logic [INDEX_W-1:0]           in_index;
    kind_t                        in_cmd;

    assign in_speaker_sample = s_axis_tdata[15:0];
    assign in_mic_word       = s_axis_tdata[47:16];
    assign in_batch_len      = s_axis_tdata[58:48];
    assign in_index          = s_axis_tdata[68:59];
    assign in_cmd            = kind_t'(s_axis_tuser);

    // registers
    logic [GAIN_W-1:0]   gain_reg;
    logic [ADDR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic                full_reg, full_next;

    logic                st1_valid_reg;
    kind_t               st1_kind_reg;
    logic                st1_neg_reg;
    logic [SAMPLE_W-1:0] st1_mag_reg;
    logic [SAMPLE_W-1:0] st1_mic_reg;
    logic                st1_ref_ok_reg;
    logic [SAMPLE_W-1:0] ref_rd_reg;

    logic                  out_valid_reg;
    kind_t                 out_kind_reg;
    logic [SPK_WORD_W-1:0] out_spk_reg;
    logic [SAMPLE_W-1:0]   out_mic_reg;
    logic [SAMPLE_W-1:0]   out_ref_reg;

    logic [SAMPLE_W-1:0] ring_mem [0:REF_DEPTH-1];

    // handshake
    logic out_free;
    logic st1_advance;
    logic in_accept;
    logic spk_accept;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign st1_advance   = st1_valid_reg && out_free;
    assign s_axis_tready = !st1_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign spk_accept    = in_accept && (in_cmd == KIND_SPEAKER);

    // volume to gain
    logic [VOLUME_W-1:0] vol_sat;

    assign vol_sat = (cfg_wr_data > VOLUME_W'(VOLUME_MAX)) ? VOLUME_W'(VOLUME_MAX)
                                                          : cfg_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_TABLE[VOLUME_RESET];
        end
        else if (cfg_wr_en)
        begin
            gain_reg <= GAIN_TABLE[vol_sat];
        end
    end

    // ring pointer and fill flag
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        full_next   = full_reg;
        if (spk_accept)
        begin
            wr_ptr_next = ADDR_W'(wr_ptr_reg + ADDR_W'(1));
            if (wr_ptr_reg == ADDR_W'(REF_DEPTH - 1))
            begin
                full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            full_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            full_reg   <= full_next;
        end
    end

    // reference read position
    logic [POS_W-1:0]  pos_sum;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_written;

    assign pos_sum = POS_W'(wr_ptr_reg) - POS_W'(ECHO_DELAY) - POS_W'(in_batch_len)
                     + POS_W'(in_index);
    assign rd_addr    = pos_sum[ADDR_W-1:0];
    assign rd_written = full_reg || (rd_addr < wr_ptr_reg);

    // reference ring
    always_ff @(posedge clk)
    begin
        if (spk_accept)
        begin
            ring_mem[wr_ptr_reg] <= in_speaker_sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ref_rd_reg <= ring_mem[rd_addr];
        end
    end

    // mic conversion
    logic signed [MIC_SHIFTED_W-1:0] mic_shifted;
    logic        [SAMPLE_W-1:0]      mic_clamped;

    assign mic_shifted = MIC_SHIFTED_W'(in_mic_word >>> MIC_SHIFT);

    always_comb
    begin
        if (mic_shifted > MIC_SHIFTED_W'(SAMPLE_MAX))
        begin
            mic_clamped = SAMPLE_W'(SAMPLE_MAX);
        end
        else if (mic_shifted < -MIC_SHIFTED_W'(SAMPLE_MAX))
        begin
            mic_clamped = SAMPLE_W'(-SAMPLE_MAX);
        end
        else
        begin
            mic_clamped = mic_shifted[SAMPLE_W-1:0];
        end
    end

    // stage one
    logic                st1_neg_next;
    logic [SAMPLE_W-1:0] st1_mag_next;
    logic [SAMPLE_W-1:0] st1_mic_next;
    logic                st1_ref_ok_next;

    always_comb
    begin
        st1_neg_next    = 1'b0;
        st1_mag_next    = '0;
        st1_mic_next    = '0;
        st1_ref_ok_next = 1'b0;
        case (in_cmd)
            KIND_SPEAKER:
            begin
                st1_neg_next = in_speaker_sample[SAMPLE_W-1];
                st1_mag_next = st1_neg_next ? SAMPLE_W'(-in_speaker_sample)
                                            : in_speaker_sample;
            end
            KIND_MIC:
            begin
                st1_mic_next    = mic_clamped;
                st1_ref_ok_next = rd_written;
            end
            default:
            begin
                st1_mag_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            st1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            st1_kind_reg   <= in_cmd;
            st1_neg_reg    <= st1_neg_next;
            st1_mag_reg    <= st1_mag_next;
            st1_mic_reg    <= st1_mic_next;
            st1_ref_ok_reg <= st1_ref_ok_next;
        end
    end

    // speaker scaling
    logic [PROD_W-1:0]     spk_prod;
    logic [SPK_WORD_W-1:0] spk_mag;
    logic [SPK_WORD_W-1:0] spk_word;

    assign spk_prod = PROD_W'(st1_mag_reg) * PROD_W'(gain_reg);
    assign spk_mag  = spk_prod[PROD_DROP +: SPK_WORD_W];
    assign spk_word = st1_neg_reg ? SPK_WORD_W'(-spk_mag) : spk_mag;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st1_advance)
        begin
            out_kind_reg <= st1_kind_reg;
            out_spk_reg  <= spk_word;
            out_mic_reg  <= st1_mic_reg;
            out_ref_reg  <= st1_ref_ok_reg ? ref_rd_reg : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {out_ref_reg, out_mic_reg, out_spk_reg};

    // checks
    `EARAP_ASSERT_NOW(a_spk_fields_zero,
        out_valid_reg && (out_kind_reg == KIND_SPEAKER),
        (out_mic_reg == '0) && (out_ref_reg == '0),
        "speaker item carries mic or reference data")

    `EARAP_ASSERT_NOW(a_mic_spk_zero,
        out_valid_reg && (out_kind_reg == KIND_MIC),
        (out_spk_reg == '0) && (out_mic_reg != 16'h8000),
        "mic item has speaker word or unclamped sample")

    `EARAP_ASSERT_NEXT(a_ptr_advance,
        spk_accept,
        wr_ptr_reg == ADDR_W'($past(wr_ptr_reg) + ADDR_W'(1)),
        "write pointer did not advance on speaker item")

    `EARAP_ASSERT_NEXT(a_full_sticky,
        full_reg,
        full_reg,
        "ring fill flag dropped")

endmodule
